/* sv/tbga_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbga_pkg
// Types and constants shared by the pairwise gravity acceleration pipeline.
// ----------------------------------------------------------------------------
package tbga_pkg;

	localparam int FIELD_W = 48;            // positions, accelerations, mu
	localparam int MAG_W   = 48;            // |p2 - p1| per axis
	localparam int HALF_W  = 32;            // low part of a split operand
	localparam int SUM_W   = 99;            // sum of squares and its remainder
	localparam int ROOT_W  = 49;            // integer square root
	localparam int R2_W    = 98;            // root squared
	localparam int DEN_W   = 147;           // root cubed
	localparam int PROD_W  = 96;            // mu * magnitude
	localparam int NUM_W   = 160;           // numerator, product shifted by 64
	localparam int NUM_SH  = 64;
	localparam int Q_W     = 47;            // quotient bits below saturation
	localparam int CMP_W   = 194;           // widest shifted denominator
	localparam int LANES   = 6;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_MU_BODY_TWO = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MU_BODY_ONE = CFG_IDX_W'(1);

	localparam logic [FIELD_W-1:0] MU_BODY_TWO_RST = 48'd33984648704000;
	localparam logic [FIELD_W-1:0] MU_BODY_ONE_RST = 48'd102037504;

	localparam logic [FIELD_W-1:0] ACC_POS_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
	localparam logic [FIELD_W-1:0] ACC_NEG_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

	typedef struct packed {
		logic signed [FIELD_W-1:0] body1_x;
		logic signed [FIELD_W-1:0] body1_y;
		logic signed [FIELD_W-1:0] body1_z;
		logic signed [FIELD_W-1:0] body2_x;
		logic signed [FIELD_W-1:0] body2_y;
		logic signed [FIELD_W-1:0] body2_z;
	} in_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] accel1_x;
		logic signed [FIELD_W-1:0] accel1_y;
		logic signed [FIELD_W-1:0] accel1_z;
		logic signed [FIELD_W-1:0] accel2_x;
		logic signed [FIELD_W-1:0] accel2_y;
		logic signed [FIELD_W-1:0] accel2_z;
		logic                      coincident;
	} out_t;

	// per-axis separation carried down the root pipeline
	typedef struct packed {
		logic [2:0][MAG_W-1:0] mag;
		logic [2:0]            neg;
		logic                  zero;
	} sep_t;

	// per-lane data carried down the divider
	typedef struct packed {
		logic [LANES-1:0]            neg;
		logic [LANES-1:0]            ovf;
		logic [LANES-1:0][Q_W-1:0]   quo;
		logic [LANES-1:0][NUM_W-1:0] rem;
		logic [DEN_W-1:0]            den;
		logic                        zero;
	} div_t;

endpackage

/* sv/two_body_gravity_accel_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_body_gravity_accel_top
// Pairwise Newtonian gravity kernel: two positions in, two accelerations out.
// ----------------------------------------------------------------------------
// Usage:
//  - in channel: one item holds both body positions (signed Q31.16 km).
//    An item is taken on a clock edge with in_valid high and in_stall low.
//  - out channel: one item per input item, accelerations in signed Q7.40
//    km/s^2, saturated, plus the coincident flag for equal positions.
//  - cfg channel: index 0 writes mu of body two, index 1 mu of body one;
//    other indexes are dropped. cfg_ready is always high. Write only while
//    the pipeline is empty.
//  - Throughput: one item per cycle while out_stall does not hold a waiting
//    result. The 49-step square root and the 47-step divider, one result bit
//    per stage, set the depth.
//  - Reset clears all valid bits and loads the default mu values.
//  - When out_stall holds a waiting result the whole pipeline freezes and
//    in_stall rises; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module two_body_gravity_accel_top
	import tbga_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_t                 out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FIELD_W-1:0]   cfg_data
);

	logic en;
	logic [FIELD_W-1:0] mu_two_q, mu_one_q;

	// Advance unless a finished item is waiting at the output
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_two_q <= MU_BODY_TWO_RST;
			mu_one_q <= MU_BODY_ONE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MU_BODY_TWO: mu_two_q <= cfg_data;
				CFG_MU_BODY_ONE: mu_one_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- stage 1: separation ----------------
	logic v_s1;
	sep_t sep_s1;
	logic signed [FIELD_W:0] dx, dy, dz;

	assign dx = (FIELD_W+1)'(in_data.body2_x) - (FIELD_W+1)'(in_data.body1_x);
	assign dy = (FIELD_W+1)'(in_data.body2_y) - (FIELD_W+1)'(in_data.body1_y);
	assign dz = (FIELD_W+1)'(in_data.body2_z) - (FIELD_W+1)'(in_data.body1_z);

	always_ff @(posedge clk) begin
		if (en) begin
			sep_s1.neg[0] <= dx[FIELD_W];
			sep_s1.neg[1] <= dy[FIELD_W];
			sep_s1.neg[2] <= dz[FIELD_W];
			sep_s1.mag[0] <= MAG_W'(dx[FIELD_W] ? -dx : dx);
			sep_s1.mag[1] <= MAG_W'(dy[FIELD_W] ? -dy : dy);
			sep_s1.mag[2] <= MAG_W'(dz[FIELD_W] ? -dz : dz);
			sep_s1.zero   <= 1'b0;
		end
	end

	// ---------------- stage 2: square partial products ----------------
	logic v_s2;
	sep_t sep_s2;
	logic [2:0][31:0] sq_hh_s2;
	logic [2:0][47:0] sq_hl_s2;
	logic [2:0][63:0] sq_ll_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sep_s2 <= sep_s1;
			for (int k = 0; k < 3; k++) begin
				sq_hh_s2[k] <= sep_s1.mag[k][MAG_W-1:HALF_W] * sep_s1.mag[k][MAG_W-1:HALF_W];
				sq_hl_s2[k] <= sep_s1.mag[k][MAG_W-1:HALF_W] * sep_s1.mag[k][HALF_W-1:0];
				sq_ll_s2[k] <= sep_s1.mag[k][HALF_W-1:0] * sep_s1.mag[k][HALF_W-1:0];
			end
		end
	end

	// ---------------- stage 3: sum of squares ----------------
	logic [SUM_W-1:0] ssum;
	always_comb begin
		ssum = '0;
		for (int k = 0; k < 3; k++)
			ssum = ssum + (SUM_W'(sq_hh_s2[k]) << 64) + (SUM_W'(sq_hl_s2[k]) << 33)
				+ SUM_W'(sq_ll_s2[k]);
	end

	// root pipeline: entry 0 is stage 3, entry i+1 holds bit 48-i resolved
	logic [ROOT_W:0]   sq_v;
	logic [SUM_W-1:0]  sq_rem  [ROOT_W+1];
	logic [ROOT_W-1:0] sq_root [ROOT_W+1];
	sep_t              sq_sep  [ROOT_W+1];

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rem[0]       <= ssum;
			sq_root[0]      <= '0;
			sq_sep[0].mag   <= sep_s2.mag;
			sq_sep[0].neg   <= sep_s2.neg;
			sq_sep[0].zero  <= (ssum == '0);
		end
	end

	// One root bit per stage
	for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
		localparam int B = ROOT_W - 1 - i;
		logic [SUM_W-1:0] trial;
		logic             take;
		always_comb begin
			trial = (SUM_W'(sq_root[i]) << (B + 1)) + (SUM_W'(1) << (2 * B));
			take  = (sq_rem[i] >= trial);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem[i+1]  <= take ? sq_rem[i] - trial : sq_rem[i];
				sq_root[i+1] <= sq_root[i] | (take ? (ROOT_W'(1) << B) : '0);
				sq_sep[i+1]  <= sq_sep[i];
			end
		end
	end

	// ---------------- P1: root square and mu*mag partial products ----------------
	logic v_p1, v_p2, v_p3, v_p4;
	logic [ROOT_W-1:0] root_p1;
	logic [33:0] r_hh_p1;
	logic [48:0] r_hl_p1;
	logic [63:0] r_ll_p1;
	logic [LANES-1:0][31:0] m_hh_p1;
	logic [LANES-1:0][47:0] m_hl_p1, m_lh_p1;
	logic [LANES-1:0][63:0] m_ll_p1;
	logic [LANES-1:0] neg_p1;
	logic zero_p1;
	logic [ROOT_W-1:0] rt;
	assign rt = sq_root[ROOT_W];

	always_ff @(posedge clk) begin
		if (en) begin
			root_p1 <= rt;
			r_hh_p1 <= rt[ROOT_W-1:HALF_W] * rt[ROOT_W-1:HALF_W];
			r_hl_p1 <= rt[ROOT_W-1:HALF_W] * rt[HALF_W-1:0];
			r_ll_p1 <= rt[HALF_W-1:0] * rt[HALF_W-1:0];
			zero_p1 <= sq_sep[ROOT_W].zero;
			for (int k = 0; k < 3; k++) begin
				m_hh_p1[k]   <= mu_two_q[47:32] * sq_sep[ROOT_W].mag[k][47:32];
				m_hl_p1[k]   <= mu_two_q[47:32] * sq_sep[ROOT_W].mag[k][31:0];
				m_lh_p1[k]   <= mu_two_q[31:0] * sq_sep[ROOT_W].mag[k][47:32];
				m_ll_p1[k]   <= mu_two_q[31:0] * sq_sep[ROOT_W].mag[k][31:0];
				m_hh_p1[k+3] <= mu_one_q[47:32] * sq_sep[ROOT_W].mag[k][47:32];
				m_hl_p1[k+3] <= mu_one_q[47:32] * sq_sep[ROOT_W].mag[k][31:0];
				m_lh_p1[k+3] <= mu_one_q[31:0] * sq_sep[ROOT_W].mag[k][47:32];
				m_ll_p1[k+3] <= mu_one_q[31:0] * sq_sep[ROOT_W].mag[k][31:0];
				neg_p1[k]    <= sq_sep[ROOT_W].neg[k];
				neg_p1[k+3]  <= !sq_sep[ROOT_W].neg[k];
			end
		end
	end

	// ---------------- P2: sum partials ----------------
	logic [ROOT_W-1:0] root_p2;
	logic [R2_W-1:0] r2_p2;
	logic [LANES-1:0][PROD_W-1:0] prod_p2, prod_p3, prod_p4;
	logic [LANES-1:0] neg_p2, neg_p3, neg_p4;
	logic zero_p2, zero_p3, zero_p4;

	always_ff @(posedge clk) begin
		if (en) begin
			root_p2 <= root_p1;
			r2_p2   <= (R2_W'(r_hh_p1) << 64) + (R2_W'(r_hl_p1) << 33) + R2_W'(r_ll_p1);
			neg_p2  <= neg_p1;
			zero_p2 <= zero_p1;
			for (int l = 0; l < LANES; l++)
				prod_p2[l] <= (PROD_W'(m_hh_p1[l]) << 64) + (PROD_W'(m_hl_p1[l]) << 32)
					+ (PROD_W'(m_lh_p1[l]) << 32) + PROD_W'(m_ll_p1[l]);
		end
	end

	// ---------------- P3: cube partial products ----------------
	logic [3:0][63:0] c_lo_p3;
	logic [3:0][48:0] c_hi_p3;
	logic [R2_W+HALF_W-1:0] r2_ext;
	assign r2_ext = (R2_W+HALF_W)'(r2_p2);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				c_lo_p3[j] <= r2_ext[j*32 +: 32] * root_p2[HALF_W-1:0];
				c_hi_p3[j] <= r2_ext[j*32 +: 32] * root_p2[ROOT_W-1:HALF_W];
			end
			prod_p3 <= prod_p2;
			neg_p3  <= neg_p2;
			zero_p3 <= zero_p2;
		end
	end

	// ---------------- P4: root cubed ----------------
	logic [DEN_W-1:0] den_p4;
	logic [DEN_W+31:0] den_sum;
	always_comb begin
		den_sum = '0;
		for (int j = 0; j < 4; j++)
			den_sum = den_sum + ((DEN_W+32)'(c_lo_p3[j]) << (32 * j))
				+ ((DEN_W+32)'(c_hi_p3[j]) << (32 * j + 32));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_p4  <= DEN_W'(den_sum);
			prod_p4 <= prod_p3;
			neg_p4  <= neg_p3;
			zero_p4 <= zero_p3;
		end
	end

	// ---------------- divider: entry 0 checks saturation ----------------
	logic [Q_W:0] dv_v;
	div_t         dv [Q_W+1];

	always_ff @(posedge clk) begin
		if (en) begin
			dv[0].neg  <= neg_p4;
			dv[0].den  <= den_p4;
			dv[0].zero <= zero_p4;
			for (int l = 0; l < LANES; l++) begin
				dv[0].rem[l] <= NUM_W'(prod_p4[l]) << NUM_SH;
				dv[0].quo[l] <= '0;
				dv[0].ovf[l] <= ((CMP_W'(prod_p4[l]) << NUM_SH) >= (CMP_W'(den_p4) << Q_W));
			end
		end
	end

	// One quotient bit per stage for all six lanes
	for (genvar i = 0; i < Q_W; i++) begin : g_div
		localparam int B = Q_W - 1 - i;
		logic [CMP_W-1:0] dsh;
		logic [LANES-1:0] take;
		always_comb begin
			dsh = CMP_W'(dv[i].den) << B;
			for (int l = 0; l < LANES; l++)
				take[l] = (CMP_W'(dv[i].rem[l]) >= dsh);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv[i+1].neg  <= dv[i].neg;
				dv[i+1].ovf  <= dv[i].ovf;
				dv[i+1].den  <= dv[i].den;
				dv[i+1].zero <= dv[i].zero;
				for (int l = 0; l < LANES; l++) begin
					dv[i+1].rem[l] <= take[l] ? dv[i].rem[l] - NUM_W'(dsh) : dv[i].rem[l];
					dv[i+1].quo[l] <= dv[i].quo[l] | (take[l] ? (Q_W'(1) << B) : '0);
				end
			end
		end
	end

	// ---------------- output: sign, saturate, coincident ----------------
	logic [LANES-1:0][FIELD_W-1:0] acc;
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (dv[Q_W].zero)
				acc[l] = '0;
			else if (dv[Q_W].ovf[l])
				acc[l] = dv[Q_W].neg[l] ? ACC_NEG_MIN : ACC_POS_MAX;
			else if (dv[Q_W].neg[l])
				acc[l] = -FIELD_W'(dv[Q_W].quo[l]);
			else
				acc[l] = FIELD_W'(dv[Q_W].quo[l]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.accel1_x   <= acc[0];
			out_data.accel1_y   <= acc[1];
			out_data.accel1_z   <= acc[2];
			out_data.accel2_x   <= acc[3];
			out_data.accel2_y   <= acc[4];
			out_data.accel2_z   <= acc[5];
			out_data.coincident <= dv[Q_W].zero;
		end
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; sq_v <= '0;
			v_p1 <= 1'b0; v_p2 <= 1'b0; v_p3 <= 1'b0; v_p4 <= 1'b0;
			dv_v <= '0; out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			sq_v      <= {sq_v[ROOT_W-1:0], v_s2};
			v_p1      <= sq_v[ROOT_W];
			v_p2      <= v_p1;
			v_p3      <= v_p2;
			v_p4      <= v_p3;
			dv_v      <= {dv_v[Q_W-1:0], v_p4};
			out_valid <= dv_v[Q_W];
		end
	end

	// Coincident bodies give all-zero accelerations
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.coincident |-> out_data.accel1_x == '0
			&& out_data.accel1_y == '0 && out_data.accel1_z == '0
			&& out_data.accel2_x == '0 && out_data.accel2_y == '0
			&& out_data.accel2_z == '0)
		else $error("coincident item with non-zero acceleration");

	// Input is held back only by a waiting result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a waiting result");

	// A stalled result holds until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule
